>>> src/dfir_pkg.sv
// ============================================================================
// dfir_pkg
// Shared types, constants and the coefficient table of the decimating
// complex lowpass FIR filter.
// ============================================================================
package dfir_pkg;

    // Filter geometry
    localparam int TAPS          = 37;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 18;
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS      = PROD_BITS + 2;
    localparam int TAP_IDX_BITS  = 6;

    // Decimation control
    localparam int FACTOR_BITS   = 7;
    localparam int PHASE_BITS    = 6;
    localparam logic [FACTOR_BITS-1:0] RESET_FACTOR = 7'd6;
    localparam logic [FACTOR_BITS-1:0] MAX_FACTOR   = 7'd64;
    localparam logic [FACTOR_BITS-1:0] MIN_FACTOR   = 7'd1;

    // One input word: a complex sample
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] real_part;
        logic signed [SAMPLE_BITS-1:0] imag_part;
    } sample_t;

    // One output word: a filtered complex sample
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_i;
        logic signed [SAMPLE_BITS-1:0] filtered_q;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                    load;      // shift a new sample into the lines
        logic                    clear;     // zero the accumulators
        logic                    mac;       // multiply tap, rotate the lines
        logic [TAP_IDX_BITS-1:0] tap;       // coefficient index for mac
        logic                    load_out;  // round and capture the result
    } cmd_t;

    // Q1.17 lowpass coefficients, symmetric about tap 18
    function automatic logic signed [COEF_BITS-1:0] coef(input logic [TAP_IDX_BITS-1:0] idx);
        logic signed [COEF_BITS-1:0] c;
        unique case (idx)
            6'd0, 6'd36:  c = 18'sd0;
            6'd1, 6'd35:  c = 18'sd15;
            6'd2, 6'd34:  c = 18'sd59;
            6'd3, 6'd33:  c = 18'sd149;
            6'd4, 6'd32:  c = 18'sd307;
            6'd5, 6'd31:  c = 18'sd553;
            6'd6, 6'd30:  c = 18'sd908;
            6'd7, 6'd29:  c = 18'sd1386;
            6'd8, 6'd28:  c = 18'sd1994;
            6'd9, 6'd27:  c = 18'sd2728;
            6'd10, 6'd26: c = 18'sd3571;
            6'd11, 6'd25: c = 18'sd4494;
            6'd12, 6'd24: c = 18'sd5455;
            6'd13, 6'd23: c = 18'sd6405;
            6'd14, 6'd22: c = 18'sd7286;
            6'd15, 6'd21: c = 18'sd8044;
            6'd16, 6'd20: c = 18'sd8627;
            6'd17, 6'd19: c = 18'sd8994;
            6'd18:        c = 18'sd9120;
            default:      c = 18'sd0;
        endcase
        return c;
    endfunction

endpackage

>>> src/dfir_datapath.sv
// ============================================================================
// dfir_datapath
// Delay lines, one multiply-accumulate unit per channel, rounding and
// saturation, and the output word register.
// ============================================================================
module dfir_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  dfir_pkg::cmd_t    cmd,
    input  dfir_pkg::sample_t sample,
    output dfir_pkg::result_t result
);

    localparam int SB = dfir_pkg::SAMPLE_BITS;
    localparam int AB = dfir_pkg::ACC_BITS;
    localparam int PB = dfir_pkg::PROD_BITS;
    localparam int RSH = dfir_pkg::COEF_BITS - 1;
    localparam int RB = AB - RSH;

    logic signed [SB-1:0] line_i_reg [dfir_pkg::TAPS];
    logic signed [SB-1:0] line_q_reg [dfir_pkg::TAPS];
    logic signed [PB-1:0] prod_i_reg, prod_q_reg;
    logic                 prod_vld_reg;
    logic signed [AB-1:0] acc_i_reg, acc_q_reg;
    dfir_pkg::result_t    result_reg;
    logic signed [dfir_pkg::COEF_BITS-1:0] coef_val;

    // Round half up to Q1.15 and saturate
    function automatic logic signed [SB-1:0] round_sat(input logic signed [AB-1:0] acc);
        logic signed [AB-1:0] biased;
        logic signed [RB-1:0] shifted;
        logic signed [RB-1:0] hi;
        logic signed [RB-1:0] lo;
        logic signed [SB-1:0] r;
        biased  = acc + (AB'(1) <<< (RSH - 1));
        shifted = RB'(biased >>> RSH);
        hi      = RB'((1 <<< (SB - 1)) - 1);
        lo      = -hi - RB'(1);
        if (shifted > hi)
            r = SB'(hi);
        else if (shifted < lo)
            r = SB'(lo);
        else
            r = SB'(shifted);
        return r;
    endfunction

    assign coef_val = dfir_pkg::coef(cmd.tap);

    // Shift a new sample in, or rotate the lines by one tap during a MAC pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dfir_pkg::TAPS; k++)
            begin
                line_i_reg[k] <= '0;
                line_q_reg[k] <= '0;
            end
        end
        else if (cmd.load)
        begin
            line_i_reg[0] <= sample.real_part;
            line_q_reg[0] <= sample.imag_part;
            for (int k = 1; k < dfir_pkg::TAPS; k++)
            begin
                line_i_reg[k] <= line_i_reg[k-1];
                line_q_reg[k] <= line_q_reg[k-1];
            end
        end
        else if (cmd.mac)
        begin
            line_i_reg[dfir_pkg::TAPS-1] <= line_i_reg[0];
            line_q_reg[dfir_pkg::TAPS-1] <= line_q_reg[0];
            for (int k = 0; k < dfir_pkg::TAPS - 1; k++)
            begin
                line_i_reg[k] <= line_i_reg[k+1];
                line_q_reg[k] <= line_q_reg[k+1];
            end
        end
    end

    // Track which cycles carry a fresh product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= cmd.mac;
    end

    // Multiply the head tap by its coefficient
    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            prod_i_reg <= PB'(line_i_reg[0] * coef_val);
            prod_q_reg <= PB'(line_q_reg[0] * coef_val);
        end
    end

    // Accumulate the registered products
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_i_reg <= acc_i_reg + AB'(prod_i_reg);
            acc_q_reg <= acc_q_reg + AB'(prod_q_reg);
        end
    end

    // Capture the rounded output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.filtered_i <= round_sat(acc_i_reg);
            result_reg.filtered_q <= round_sat(acc_q_reg);
        end
    end

    assign result = result_reg;

endmodule

>>> src/dfir_ctrl.sv
// ============================================================================
// dfir_ctrl
// Controller: input and output handshakes, decimation phase, factor
// register and the sequencing of one MAC pass over the taps.
// ============================================================================
module dfir_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 cfg_wr_en,
    input  logic [dfir_pkg::FACTOR_BITS-1:0]     cfg_wr_data,
    output dfir_pkg::cmd_t                       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_WRITE
    } state_t;

    localparam int FB = dfir_pkg::FACTOR_BITS;
    localparam int PHB = dfir_pkg::PHASE_BITS;
    localparam int TB = dfir_pkg::TAP_IDX_BITS;
    localparam logic [TB-1:0] LAST_TAP = TB'(dfir_pkg::TAPS - 1);

    state_t           state_reg, state_next;
    logic [TB-1:0]    tap_reg, tap_next;
    logic [PHB-1:0]   phase_reg, phase_next;
    logic [FB-1:0]    factor_reg, factor_next;
    logic             out_valid_reg, out_valid_next;

    logic [FB-1:0]    factor_eff;
    logic [FB-1:0]    phase_inc;
    logic             accept;
    logic             emit;
    logic             out_free;

    // Clamp the factor to the range the phase counter can reach
    always_comb
    begin
        if (factor_reg == '0)
            factor_eff = dfir_pkg::MIN_FACTOR;
        else if (factor_reg > dfir_pkg::MAX_FACTOR)
            factor_eff = dfir_pkg::MAX_FACTOR;
        else
            factor_eff = factor_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign phase_inc = FB'(phase_reg) + FB'(1);
    assign emit      = (phase_inc >= factor_eff);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        phase_next     = phase_reg;
        factor_next    = factor_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.tap        = tap_reg;

        if (cfg_wr_en)
            factor_next = cfg_wr_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (emit)
                    begin
                        cmd.clear  = 1'b1;
                        phase_next = '0;
                        tap_next   = '0;
                        state_next = ST_MAC;
                    end
                    else
                        phase_next = phase_inc[PHB-1:0];
                end
            end
            ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (tap_reg == LAST_TAP)
                    state_next = ST_FLUSH;
                else
                    tap_next = tap_reg + TB'(1);
            end
            ST_FLUSH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            phase_reg     <= '0;
            factor_reg    <= dfir_pkg::RESET_FACTOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            phase_reg     <= phase_next;
            factor_reg    <= factor_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/decimating_iq_fir_lowpass.sv
// ============================================================================
// decimating_iq_fir_lowpass
// Decimating 37-tap complex lowpass FIR filter on Q1.15 I/Q samples.
// ============================================================================
// An accepted sample word is shifted into the I and Q delay lines. Every
// Nth word (N from the decimation register, 0 read as 1, above 64 read as
// 64) starts a filter pass: one multiply-accumulate unit per channel walks
// the 37 taps, one per cycle, by rotating the delay lines past a fixed head
// tap, so the input stalls after that word through the tap steps, the
// accumulate step for the last product and the round/saturate step, plus
// any wait for the output register to free up. A word that does not
// complete a decimation period is only shifted in and counted. The reset
// factor is 6. The result is rounded half up to Q1.15, saturated, and held
// in an output register, so new input words are accepted while a result
// waits downstream. Write the decimation factor only while the filter is
// idle.
// ============================================================================
module decimating_iq_fir_lowpass (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  dfir_pkg::sample_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output dfir_pkg::result_t                out_data,
    input  logic                             cfg_wr_en,
    input  logic [dfir_pkg::FACTOR_BITS-1:0] cfg_wr_data
);

    dfir_pkg::cmd_t cmd;

    // Sequence handshakes and the MAC pass
    dfir_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd)
    );

    // Delay lines, MAC units and output word
    dfir_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sample (in_data),
        .result (out_data)
    );

endmodule
